### design/ttss_pkg.sv
// Shared types, sizes and codes of the tick task scheduler table.
package ttss_pkg;

	localparam int SLOTS = 8;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam logic [1:0] MODE_TICK     = 2'd0;
	localparam logic [1:0] MODE_ADD      = 2'd1;
	localparam logic [1:0] MODE_REMOVE   = 2'd2;
	localparam logic [1:0] MODE_DISPATCH = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_INVALID   = 2'd2;
	localparam logic [1:0] ST_PREVENTED = 2'd3;

	typedef struct packed {
		logic        valid;
		logic [7:0]  tag;
		logic [15:0] delay;
		logic [15:0] period;
		logic        run;
	} slot_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic             guard;
		logic [IDX_W-1:0] idx;
		logic [3:0]       rslot;
		logic             add_pending;
		logic [7:0]       tag;
		logic [15:0]      delay;
		logic [15:0]      period;
	} head_ctl_t;

	typedef struct packed {
		logic       emit;
		logic       took_add;
		logic       rm_hit;
		logic [1:0] rm_status;
		logic       rm_dec;
	} head_res_t;

endpackage

### design/tick_task_scheduler_table.sv
// Tick task scheduler table: SLOTS task slots held in a ring of cells. Every request
// (tick, add, remove, dispatch) rotates the ring once, one slot per cycle through the
// update logic at its head unless a dispatch stalls it, and then presents its result
// from a final state: s_tready drops at acceptance and returns only once the request is
// finished, so no new request is taken before the last one is through, whatever the
// mode. Dispatch sends one result per flagged slot while the ring turns and stalls the
// rotation whenever the output register is still occupied; a tick, add or remove, or a
// dispatch with no flagged slot, whose result finds the output register occupied waits
// in the same way before it frees the input. Slot contents change only through the
// head of the ring. Only one request is in flight at a time; a result waiting in the
// output register does not block acceptance of the next request. Results of tick, add
// and remove appear after the full rotation; task_count always shows the occupancy
// after the whole request, since dispatch works out its one-shot removals at acceptance.
// prevent_flagged_removal resets to 1 and is written through cfg_wen / cfg_wdata; the
// user must write it only while the block is idle, which the block does not enforce.
// No clearing pass follows reset.
module tick_task_scheduler_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,   // prevent_flagged_removal
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,     // task_tag[7:0], start_delay[23:8], repeat_period[39:24],
	                                 // slot_to_remove[43:40], zero[47:44]
	input  logic [1:0]  s_tuser,     // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,     // status[1:0], slot[5:2], fired_tag[13:6],
	                                 // task_count[17:14], zero[23:18]
	output logic        m_tuser,     // fired
	output logic        m_tlast      // last result of the request
);

	localparam int SLOTS = ttss_pkg::SLOTS;
	localparam int IDX_W = ttss_pkg::IDX_W;
	localparam int CNT_W = ttss_pkg::CNT_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	// Control state
	logic [1:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] count_q;
	logic             guard_q;
	logic             add_pending_q;
	logic             any_fired_q;
	logic [IDX_W-1:0] last_idx_q;

	// Request and result holding
	logic [1:0]       mode_q;
	logic [7:0]       tag_q;
	logic [15:0]      delay_q;
	logic [15:0]      period_q;
	logic [3:0]       rslot_q;
	logic [1:0]       status_q;
	logic [3:0]       slot_res_q;

	// Output register
	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [3:0]       out_slot_q;
	logic [7:0]       out_tag_q;
	logic             out_fired_q;
	logic [3:0]       out_count_q;
	logic             out_last_q;

	ttss_pkg::slot_t     cell_q [SLOTS];
	ttss_pkg::slot_t     head_out;
	ttss_pkg::head_ctl_t head_ctl;
	ttss_pkg::head_res_t head_res;

	logic             in_acc;
	logic             out_free;
	logic             advance;
	logic             full;
	logic [CNT_W-1:0] disp_rm;
	logic             disp_any;
	logic [IDX_W-1:0] disp_last;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign full     = (count_q >= CNT_W'(SLOTS));
	// Stall the ring while a dispatch result cannot be placed in the output register
	assign advance  = (state_q == S_RUN) && (!head_res.emit || out_free);

	// Ring of slot cells: cell 0 feeds the head, the head refills the last cell
	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		if (k == SLOTS - 1) begin : g_tail
			ttss_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (advance),
				.slot_in  (head_out),
				.slot_out (cell_q[k])
			);
		end else begin : g_mid
			ttss_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (advance),
				.slot_in  (cell_q[k+1]),
				.slot_out (cell_q[k])
			);
		end
	end

	always_comb begin
		head_ctl.mode        = mode_q;
		head_ctl.guard       = guard_q;
		head_ctl.idx         = idx_q;
		head_ctl.rslot       = rslot_q;
		head_ctl.add_pending = add_pending_q;
		head_ctl.tag         = tag_q;
		head_ctl.delay       = delay_q;
		head_ctl.period      = period_q;
	end

	ttss_head u_head (
		.ctl      (head_ctl),
		.slot_in  (cell_q[0]),
		.slot_out (head_out),
		.res      (head_res)
	);

	// At rest every slot sits in its own cell: count one-shot removals and find the
	// highest flagged slot, so dispatch knows its final count and its last result
	always_comb begin
		disp_rm   = '0;
		disp_any  = 1'b0;
		disp_last = '0;
		for (int k = 0; k < SLOTS; k++) begin
			if (cell_q[k].valid && cell_q[k].run) begin
				disp_any  = 1'b1;
				disp_last = IDX_W'(k);
				if (cell_q[k].period == 16'd0) begin
					disp_rm = disp_rm + CNT_W'(1);
				end
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			idx_q         <= '0;
			count_q       <= '0;
			guard_q       <= 1'b1;
			add_pending_q <= 1'b0;
			any_fired_q   <= 1'b0;
			last_idx_q    <= '0;
			mode_q        <= ttss_pkg::MODE_TICK;
			status_q      <= ttss_pkg::ST_OK;
			slot_res_q    <= '0;
		end else begin
			if (cfg_wen) begin
				guard_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						mode_q        <= s_tuser;
						idx_q         <= '0;
						slot_res_q    <= '0;
						add_pending_q <= (s_tuser == ttss_pkg::MODE_ADD) && !full;
						any_fired_q   <= disp_any;
						last_idx_q    <= disp_last;
						if (s_tuser == ttss_pkg::MODE_REMOVE) begin
							status_q <= ttss_pkg::ST_INVALID;
						end else if (s_tuser == ttss_pkg::MODE_ADD && full) begin
							status_q <= ttss_pkg::ST_FULL;
						end else begin
							status_q <= ttss_pkg::ST_OK;
						end
						if (s_tuser == ttss_pkg::MODE_DISPATCH) begin
							count_q <= count_q - disp_rm;
						end
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (advance) begin
						idx_q <= idx_q + IDX_W'(1);
						if (head_res.took_add) begin
							slot_res_q    <= 4'(idx_q);
							add_pending_q <= 1'b0;
							count_q       <= count_q + CNT_W'(1);
						end
						if (head_res.rm_hit) begin
							status_q <= head_res.rm_status;
						end
						if (head_res.rm_dec) begin
							count_q <= count_q - CNT_W'(1);
						end
						if (idx_q == IDX_W'(SLOTS - 1)) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					// Dispatch that fired has already sent all its results
					if ((mode_q == ttss_pkg::MODE_DISPATCH && any_fired_q) || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Input payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			tag_q    <= s_tdata[7:0];
			delay_q  <= s_tdata[23:8];
			period_q <= s_tdata[39:24];
			rslot_q  <= s_tdata[43:40];
		end
	end

	// Output register: hold the result until the downstream side takes it
	logic load_disp;
	logic load_fin;

	assign load_disp = advance && head_res.emit;
	assign load_fin  = (state_q == S_FIN) && out_free &&
	                   !(mode_q == ttss_pkg::MODE_DISPATCH && any_fired_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_disp || load_fin) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_disp) begin
			out_status_q <= ttss_pkg::ST_OK;
			out_slot_q   <= 4'(idx_q);
			out_tag_q    <= cell_q[0].tag;
			out_fired_q  <= 1'b1;
			out_count_q  <= 4'(count_q);
			out_last_q   <= (idx_q == last_idx_q);
		end else if (load_fin) begin
			out_status_q <= status_q;
			out_slot_q   <= slot_res_q;
			out_tag_q    <= 8'd0;
			out_fired_q  <= 1'b0;
			out_count_q  <= 4'(count_q);
			out_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_count_q, out_tag_q, out_slot_q, out_status_q};
	assign m_tuser  = out_fired_q;
	assign m_tlast  = out_last_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("occupancy count beyond slot count");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && !advance) |=> $stable(idx_q))
		else $error("ring position moved during a stall");

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_fired_q) |-> (out_status_q == ttss_pkg::ST_OK))
		else $error("dispatched task result with non-success status");

	a_add_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && head_res.took_add) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("add did not raise the occupancy count");

endmodule

### design/ttss_cell.sv
// One slot cell of the rotating ring: holds a slot and passes it on when the ring advances.
module ttss_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  ttss_pkg::slot_t slot_in,
	output ttss_pkg::slot_t slot_out
);

	ttss_pkg::slot_t slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (shift) begin
			slot_q <= slot_in;
		end
	end

	assign slot_out = slot_q;

endmodule

### design/ttss_head.sv
// Update logic at the head of the ring: applies the current request to one slot.
module ttss_head (
	input  ttss_pkg::head_ctl_t ctl,
	input  ttss_pkg::slot_t     slot_in,
	output ttss_pkg::slot_t     slot_out,
	output ttss_pkg::head_res_t res
);

	logic [15:0] dly;

	always_comb begin
		slot_out = slot_in;
		res      = '0;
		dly      = slot_in.delay;
		unique case (ctl.mode)
			ttss_pkg::MODE_TICK: begin
				if (slot_in.valid) begin
					if (slot_in.delay == 16'd0) begin
						slot_out.run = 1'b1;
						if (slot_in.period != 16'd0) begin
							dly = slot_in.period;
						end
					end
					slot_out.delay = dly - 16'd1;
				end
			end
			ttss_pkg::MODE_ADD: begin
				if (ctl.add_pending && !slot_in.valid) begin
					slot_out.valid  = 1'b1;
					slot_out.tag    = ctl.tag;
					slot_out.delay  = ctl.delay;
					slot_out.period = ctl.period;
					slot_out.run    = (ctl.delay == 16'd0);
					res.took_add    = 1'b1;
				end
			end
			ttss_pkg::MODE_REMOVE: begin
				if (4'(ctl.idx) == ctl.rslot) begin
					res.rm_hit = 1'b1;
					if (!slot_in.valid) begin
						res.rm_status = ttss_pkg::ST_INVALID;
					end else if (slot_in.run && ctl.guard) begin
						slot_out.period = 16'd0;
						res.rm_status   = ttss_pkg::ST_PREVENTED;
					end else begin
						slot_out      = '0;
						res.rm_status = ttss_pkg::ST_OK;
						res.rm_dec    = 1'b1;
					end
				end
			end
			ttss_pkg::MODE_DISPATCH: begin
				if (slot_in.valid && slot_in.run) begin
					res.emit     = 1'b1;
					slot_out.run = 1'b0;
					if (slot_in.period == 16'd0) begin
						slot_out = '0;
					end
				end
			end
		endcase
	end

endmodule
